>>> rtl/core/same_track_request_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Same-track request queue assertion macros
// Shared assertion forms for the queue checker.
// ----------------------------------------------------------------------------
`ifndef SAME_TRACK_REQUEST_QUEUE_TOP_MACROS_SVH
`define SAME_TRACK_REQUEST_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define STQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/stq_pkg.sv
// ----------------------------------------------------------------------------
// Same-track request queue package
// Shared types and constants for the queue cells and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stq_pkg;

    localparam int unsigned QUEUE_DEPTH = 64;
    localparam int unsigned TRACK_BITS  = 10;
    localparam int unsigned SECTOR_BITS = 5;
    localparam int unsigned ARRIVAL_BITS = 32;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic enq;
        logic deq;
        logic any_found;
    } t_cell_ctl;

endpackage

>>> rtl/core/same_track_request_queue_top.sv
// ----------------------------------------------------------------------------
// Same-track request queue top level
// Ordered request queue: an enqueue lands directly behind the first held
// request on the same track, or at the tail; a dequeue pops the head.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command item:
//   enqueue with track, sector and arrival stamp, or dequeue of the head.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   item per command: status, the popped request (zero otherwise), the
//   empty flag and the occupancy after the command.
//   Latency: the result is valid in the cycle after the item is accepted.
//   Throughput: one item per cycle when not stalled. Each command is done
//   in a single pass through the row of cells: every cell compares its
//   track, the first match ripples down, and the cells update at the edge.
//   Stall: while a result waits and i_out_ready is low, o_in_ready is low.
//   Reset: the queue is emptied and no result is pending; slot contents
//   are left as they are and never read before being written.
//   Errors: dequeue on empty and enqueue on full leave the queue unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module same_track_request_queue_top #(
    parameter int unsigned QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH,
    parameter int unsigned TRACK_BITS  = stq_pkg::TRACK_BITS,
    localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [TRACK_BITS-1:0]             i_req_track,
    input  logic [stq_pkg::SECTOR_BITS-1:0]   i_req_sector,
    input  logic [stq_pkg::ARRIVAL_BITS-1:0]  i_req_arrival,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [TRACK_BITS-1:0]             o_out_track,
    output logic [stq_pkg::SECTOR_BITS-1:0]   o_out_sector,
    output logic [stq_pkg::ARRIVAL_BITS-1:0]  o_out_arrival,
    output logic                              o_queue_empty,
    output logic [CW-1:0]                     o_occupancy
);

    logic [CW-1:0]                    r_count, n_count;
    logic                             r_out_valid, n_out_valid;
    stq_pkg::t_status                 r_status, n_status;
    logic [TRACK_BITS-1:0]            r_track, n_track;
    logic [stq_pkg::SECTOR_BITS-1:0]  r_sector, n_sector;
    logic [stq_pkg::ARRIVAL_BITS-1:0] r_arrival, n_arrival;

    logic w_accept, w_full, w_empty, w_enq_ok, w_deq_ok;
    stq_pkg::t_cell_ctl w_ctl;

    logic [QUEUE_DEPTH:0]             w_found;
    logic [QUEUE_DEPTH:0]             w_ins;
    logic [TRACK_BITS-1:0]            w_track   [QUEUE_DEPTH];
    logic [stq_pkg::SECTOR_BITS-1:0]  w_sector  [QUEUE_DEPTH];
    logic [stq_pkg::ARRIVAL_BITS-1:0] w_arrival [QUEUE_DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_enq_ok   = w_accept && (i_command == stq_pkg::CMD_ENQ) && !w_full;
    assign w_deq_ok   = w_accept && (i_command == stq_pkg::CMD_DEQ) && !w_empty;

    assign w_found[0] = 1'b0;
    assign w_ins[0]   = 1'b0;

    always_comb begin
        w_ctl.enq       = w_enq_ok;
        w_ctl.deq       = w_deq_ok;
        w_ctl.any_found = w_found[QUEUE_DEPTH];
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [TRACK_BITS-1:0]            w_prev_trk, w_next_trk;
        logic [stq_pkg::SECTOR_BITS-1:0]  w_prev_sec, w_next_sec;
        logic [stq_pkg::ARRIVAL_BITS-1:0] w_prev_arr, w_next_arr;

        if (g == 0) begin : g_first
            assign w_prev_trk = '0;
            assign w_prev_sec = '0;
            assign w_prev_arr = '0;
        end else begin : g_mid_prev
            assign w_prev_trk = w_track[g-1];
            assign w_prev_sec = w_sector[g-1];
            assign w_prev_arr = w_arrival[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next_trk = '0;
            assign w_next_sec = '0;
            assign w_next_arr = '0;
        end else begin : g_mid_next
            assign w_next_trk = w_track[g+1];
            assign w_next_sec = w_sector[g+1];
            assign w_next_arr = w_arrival[g+1];
        end

        stq_cell #(
            .TRACK_BITS (TRACK_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_held         (CW'(g) < r_count),
            .i_tail         (CW'(g) == r_count),
            .i_req_track    (i_req_track),
            .i_req_sector   (i_req_sector),
            .i_req_arrival  (i_req_arrival),
            .i_found        (w_found[g]),
            .i_ins          (w_ins[g]),
            .o_found        (w_found[g+1]),
            .o_ins          (w_ins[g+1]),
            .i_prev_track   (w_prev_trk),
            .i_prev_sector  (w_prev_sec),
            .i_prev_arrival (w_prev_arr),
            .i_next_track   (w_next_trk),
            .i_next_sector  (w_next_sec),
            .i_next_arrival (w_next_arr),
            .o_track        (w_track[g]),
            .o_sector       (w_sector[g]),
            .o_arrival      (w_arrival[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_track     = r_track;
        n_sector    = r_sector;
        n_arrival   = r_arrival;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = stq_pkg::ST_OK;
            n_track     = '0;
            n_sector    = '0;
            n_arrival   = '0;
            if (i_command == stq_pkg::CMD_ENQ) begin
                if (w_full) begin
                    n_status = stq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = stq_pkg::ST_EMPTY;
                end else begin
                    n_count   = r_count - CW'(1);
                    n_track   = w_track[0];
                    n_sector  = w_sector[0];
                    n_arrival = w_arrival[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_track   <= n_track;
        r_sector  <= n_sector;
        r_arrival <= n_arrival;
    end

    logic [CW-1:0] r_occ, n_occ;
    logic          r_empty_flag, n_empty_flag;

    always_comb begin
        n_occ        = r_occ;
        n_empty_flag = r_empty_flag;
        if (w_accept) begin
            n_occ        = n_count;
            n_empty_flag = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_occ        <= n_occ;
        r_empty_flag <= n_empty_flag;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_track   = r_track;
    assign o_out_sector  = r_sector;
    assign o_out_arrival = r_arrival;
    assign o_queue_empty = r_empty_flag;
    assign o_occupancy   = r_occ;

endmodule

>>> rtl/core/stq_cell.sv
// ----------------------------------------------------------------------------
// Same-track request queue cell
// One queue slot: compares its track, ripples the first-match flag and
// takes data from a neighbor or from the incoming item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_cell #(
    parameter int unsigned TRACK_BITS = stq_pkg::TRACK_BITS
) (
    input  logic                              i_clk,
    input  stq_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_held,
    input  logic                              i_tail,
    input  logic [TRACK_BITS-1:0]             i_req_track,
    input  logic [stq_pkg::SECTOR_BITS-1:0]   i_req_sector,
    input  logic [stq_pkg::ARRIVAL_BITS-1:0]  i_req_arrival,
    input  logic                              i_found,
    input  logic                              i_ins,
    output logic                              o_found,
    output logic                              o_ins,
    input  logic [TRACK_BITS-1:0]             i_prev_track,
    input  logic [stq_pkg::SECTOR_BITS-1:0]   i_prev_sector,
    input  logic [stq_pkg::ARRIVAL_BITS-1:0]  i_prev_arrival,
    input  logic [TRACK_BITS-1:0]             i_next_track,
    input  logic [stq_pkg::SECTOR_BITS-1:0]   i_next_sector,
    input  logic [stq_pkg::ARRIVAL_BITS-1:0]  i_next_arrival,
    output logic [TRACK_BITS-1:0]             o_track,
    output logic [stq_pkg::SECTOR_BITS-1:0]   o_sector,
    output logic [stq_pkg::ARRIVAL_BITS-1:0]  o_arrival
);

    logic [TRACK_BITS-1:0]            r_track,   n_track;
    logic [stq_pkg::SECTOR_BITS-1:0]  r_sector,  n_sector;
    logic [stq_pkg::ARRIVAL_BITS-1:0] r_arrival, n_arrival;
    logic                             w_match;

    assign w_match = i_held && (r_track == i_req_track);
    assign o_found = i_found | w_match;
    assign o_ins   = w_match & ~i_found;

    always_comb begin
        n_track   = r_track;
        n_sector  = r_sector;
        n_arrival = r_arrival;
        if (i_ctl.enq) begin
            if (i_ins || (i_tail && !i_ctl.any_found)) begin
                n_track   = i_req_track;
                n_sector  = i_req_sector;
                n_arrival = i_req_arrival;
            end else if (i_found) begin
                n_track   = i_prev_track;
                n_sector  = i_prev_sector;
                n_arrival = i_prev_arrival;
            end
        end else if (i_ctl.deq) begin
            n_track   = i_next_track;
            n_sector  = i_next_sector;
            n_arrival = i_next_arrival;
        end
    end

    always_ff @(posedge i_clk) begin
        r_track   <= n_track;
        r_sector  <= n_sector;
        r_arrival <= n_arrival;
    end

    assign o_track   = r_track;
    assign o_sector  = r_sector;
    assign o_arrival = r_arrival;

endmodule

>>> rtl/core/stq_checker.sv
// ----------------------------------------------------------------------------
// Same-track request queue checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "same_track_request_queue_top_macros.svh"

module stq_checker #(
    parameter int unsigned QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH,
    localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input logic [1:0]    o_status,
    input logic          o_queue_empty,
    input logic [CW-1:0] o_occupancy
);

    `STQ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `STQ_ASSERT_NOW(a_empty_flag, o_out_valid, o_queue_empty == (o_occupancy == '0), "empty flag disagrees with occupancy")
    `STQ_ASSERT_NOW(a_deq_empty, o_out_valid && (o_status == stq_pkg::ST_EMPTY), o_occupancy == '0, "empty error with requests held")
    `STQ_ASSERT_NOW(a_enq_full, o_out_valid && (o_status == stq_pkg::ST_FULL), o_occupancy == CW'(QUEUE_DEPTH), "full error with queue not full")

endmodule

bind same_track_request_queue_top stq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_stq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_queue_empty (o_queue_empty),
    .o_occupancy   (o_occupancy)
);
